// File: hdl/lpg_pkg.sv
// shared constants and types for the line pixel generator
`timescale 1ns / 1ps
`default_nettype none
package lpg_pkg;

   localparam int COORD_BITS   = 10;
   localparam int PAGE_BITS    = 16;
   localparam int COLOR_BITS   = 8;
   localparam int PROD_BITS    = 2 * COORD_BITS;
   localparam int DIV_CNT_BITS = $clog2(COORD_BITS + 1);

   localparam logic OP_START = 1'b0;
   localparam logic OP_NEXT  = 1'b1;

   typedef logic [COORD_BITS-1:0]        coord_type;
   typedef logic signed [COORD_BITS:0]   delta_type;
   typedef logic [PROD_BITS-1:0]         prod_type;
   typedef logic [PAGE_BITS-1:0]         page_type;
   typedef logic [COLOR_BITS-1:0]        color_type;

endpackage
`default_nettype wire

// File: hdl/lpg_if.sv
// request and response channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface lpg_req_if;
   import lpg_pkg::*;

   logic      valid;
   logic      ready;
   logic      operation;
   coord_type x_start;
   coord_type y_start;
   coord_type x_end;
   coord_type y_end;
   page_type  page_base;
   color_type pen_color;

   modport source (
      output valid, operation, x_start, y_start, x_end, y_end, page_base, pen_color,
      input  ready
   );
   modport sink (
      input  valid, operation, x_start, y_start, x_end, y_end, page_base, pen_color,
      output ready
   );
endinterface

interface lpg_rsp_if;
   import lpg_pkg::*;

   logic      valid;
   logic      ready;
   coord_type pixel_x;
   coord_type pixel_y;
   page_type  pixel_page;
   color_type pixel_color;
   logic      last_pixel;

   modport source (
      output valid, pixel_x, pixel_y, pixel_page, pixel_color, last_pixel,
      input  ready
   );
   modport sink (
      input  valid, pixel_x, pixel_y, pixel_page, pixel_color, last_pixel,
      output ready
   );
endinterface
`default_nettype wire

// File: hdl/lpg_div.sv
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module lpg_div (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire lpg_pkg::prod_type dividend,
   input  wire lpg_pkg::coord_type divisor,
   output      lpg_pkg::coord_type quotient,
   output      logic              done
);
   import lpg_pkg::*;

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   coord_type               rem_ff, rem_in;
   coord_type               quo_ff, quo_in;
   coord_type               dvs_ff, dvs_in;
   logic [COORD_BITS:0]     trial;
   logic [COORD_BITS:0]     diff;

   assign trial = {rem_ff, quo_ff[COORD_BITS-1]};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = dividend[PROD_BITS-1:COORD_BITS];
         quo_in  = dividend[COORD_BITS-1:0];
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = diff[COORD_BITS-1:0];
            quo_in = {quo_ff[COORD_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[COORD_BITS-1:0];
            quo_in = {quo_ff[COORD_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_BITS'(COORD_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule
`default_nettype wire

// File: hdl/line_pixel_generator.sv
// line pixel generator top level: sequencer, line state and output register
// start item: S_EMIT loads the output register, then the sequencer goes idle
// next item: S_MUL multiplies, S_DIV divides, S_EMIT loads the output register
// a new item is accepted only in S_IDLE; S_EMIT waits while the output is stalled
// a next item with no active line is dropped without a pixel
// synchronous reset clears the line state, x major, no active line
`timescale 1ns / 1ps
`default_nettype none
module line_pixel_generator (
   input wire logic clock,
   input wire logic reset,
   lpg_req_if.sink   req_chan,
   lpg_rsp_if.source rsp_chan
);
   import lpg_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_MUL  = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;
   localparam logic [1:0] S_EMIT = 2'd3;

   logic [1:0] state_ff, state_in;

   coord_type major_start_ff, major_start_in;
   coord_type major_end_ff, major_end_in;
   coord_type minor_start_ff, minor_start_in;
   delta_type minor_delta_ff, minor_delta_in;
   coord_type major_current_ff, major_current_in;
   logic      x_is_major_ff, x_is_major_in;
   logic      line_active_ff, line_active_in;
   page_type  saved_page_ff, saved_page_in;
   color_type saved_color_ff, saved_color_in;
   coord_type minor_ff, minor_in;
   logic      last_ff, last_in;

   logic      rsp_valid_ff, rsp_valid_in;
   coord_type rsp_x_ff, rsp_x_in;
   coord_type rsp_y_ff, rsp_y_in;
   page_type  rsp_page_ff, rsp_page_in;
   color_type rsp_color_ff, rsp_color_in;
   logic      rsp_last_ff, rsp_last_in;

   logic      req_xfer;
   coord_type dx, dy;
   logic      xm;
   coord_type a0, a1, b0, b1;
   coord_type offset, span, delta_mag;
   prod_type  product;
   coord_type next_current;
   logic      div_start, div_done;
   coord_type quotient;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_xfer       = req_chan.valid && req_chan.ready;

   // endpoint ordering for a start transfer
   always_comb begin
      dx = (req_chan.x_end >= req_chan.x_start) ? req_chan.x_end - req_chan.x_start
                                                : req_chan.x_start - req_chan.x_end;
      dy = (req_chan.y_end >= req_chan.y_start) ? req_chan.y_end - req_chan.y_start
                                                : req_chan.y_start - req_chan.y_end;
      xm = (dx >= dy);
      if (xm) begin
         a0 = req_chan.x_start; a1 = req_chan.x_end;
         b0 = req_chan.y_start; b1 = req_chan.y_end;
      end else begin
         a0 = req_chan.y_start; a1 = req_chan.y_end;
         b0 = req_chan.x_start; b1 = req_chan.x_end;
      end
      if (a1 < a0) begin
         a0 = xm ? req_chan.x_end : req_chan.y_end;
         a1 = xm ? req_chan.x_start : req_chan.y_start;
         b0 = xm ? req_chan.y_end : req_chan.x_end;
         b1 = xm ? req_chan.y_start : req_chan.x_start;
      end
   end

   assign offset       = major_current_ff - major_start_ff;
   assign span         = major_end_ff - major_start_ff;
   assign delta_mag    = minor_delta_ff[COORD_BITS] ? COORD_BITS'(-minor_delta_ff)
                                                    : minor_delta_ff[COORD_BITS-1:0];
   assign product      = prod_type'(offset) * prod_type'(delta_mag);
   assign next_current = major_current_ff + 1'b1;
   assign div_start    = (state_ff == S_MUL);

   lpg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (product),
      .divisor  (span),
      .quotient (quotient),
      .done     (div_done)
   );

   always_comb begin
      state_in         = state_ff;
      major_start_in   = major_start_ff;
      major_end_in     = major_end_ff;
      minor_start_in   = minor_start_ff;
      minor_delta_in   = minor_delta_ff;
      major_current_in = major_current_ff;
      x_is_major_in    = x_is_major_ff;
      line_active_in   = line_active_ff;
      saved_page_in    = saved_page_ff;
      saved_color_in   = saved_color_ff;
      minor_in         = minor_ff;
      last_in          = last_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_chan.ready;
      rsp_x_in         = rsp_x_ff;
      rsp_y_in         = rsp_y_ff;
      rsp_page_in      = rsp_page_ff;
      rsp_color_in     = rsp_color_ff;
      rsp_last_in      = rsp_last_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               if (req_chan.operation == OP_START) begin
                  major_start_in   = a0;
                  major_end_in     = a1;
                  minor_start_in   = b0;
                  minor_delta_in   = delta_type'({1'b0, b1}) - delta_type'({1'b0, b0});
                  major_current_in = a0;
                  x_is_major_in    = xm;
                  line_active_in   = (a0 != a1);
                  saved_page_in    = req_chan.page_base;
                  saved_color_in   = req_chan.pen_color;
                  minor_in         = b0;
                  last_in          = (a0 == a1);
                  state_in         = S_EMIT;
               end else if (line_active_ff) begin
                  major_current_in = next_current;
                  last_in          = (next_current >= major_end_ff);
                  line_active_in   = !(next_current >= major_end_ff);
                  state_in         = S_MUL;
               end
            end
         end
         S_MUL: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               minor_in = minor_delta_ff[COORD_BITS] ? minor_start_ff - quotient
                                                     : minor_start_ff + quotient;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = x_is_major_ff ? major_current_ff : minor_ff;
               rsp_y_in     = x_is_major_ff ? minor_ff : major_current_ff;
               rsp_page_in  = saved_page_ff;
               rsp_color_in = saved_color_ff;
               rsp_last_in  = last_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         major_start_ff   <= '0;
         major_end_ff     <= '0;
         minor_start_ff   <= '0;
         minor_delta_ff   <= '0;
         major_current_ff <= '0;
         x_is_major_ff    <= 1'b1;
         line_active_ff   <= 1'b0;
         saved_page_ff    <= '0;
         saved_color_ff   <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         major_start_ff   <= major_start_in;
         major_end_ff     <= major_end_in;
         minor_start_ff   <= minor_start_in;
         minor_delta_ff   <= minor_delta_in;
         major_current_ff <= major_current_in;
         x_is_major_ff    <= x_is_major_in;
         line_active_ff   <= line_active_in;
         saved_page_ff    <= saved_page_in;
         saved_color_ff   <= saved_color_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      minor_ff     <= minor_in;
      last_ff      <= last_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_page_ff  <= rsp_page_in;
      rsp_color_ff <= rsp_color_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.pixel_x     = rsp_x_ff;
   assign rsp_chan.pixel_y     = rsp_y_ff;
   assign rsp_chan.pixel_page  = rsp_page_ff;
   assign rsp_chan.pixel_color = rsp_color_ff;
   assign rsp_chan.last_pixel  = rsp_last_ff;

endmodule
`default_nettype wire

// File: tb/line_pixel_generator_test.sv
// testbench for the line pixel generator: directed and random line draws checked pixel by pixel
`timescale 1ns / 1ps
module line_pixel_generator_test;
   import lpg_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_AT      = 300;
   localparam int HOLD_CYCLES  = 500;
   localparam int LINE_ITEMS   = 1150;
   localparam int COORD_MAX    = (1 << COORD_BITS) - 1;

   typedef struct packed {
      logic      operation;
      coord_type x_start;
      coord_type y_start;
      coord_type x_end;
      coord_type y_end;
      page_type  page_base;
      color_type pen_color;
      logic [3:0] gap;
   } line_cmd_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      page_type  page;
      color_type color;
      logic      last;
   } pixel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lpg_req_if req_chan ();
   lpg_rsp_if rsp_chan ();

   line_pixel_generator dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #5 clock = ~clock;

   line_cmd_type cmds_pending[$];
   pixel_type    pixels_due[$];

   // line tracer state
   coord_type trace_major_lo;
   coord_type trace_major_hi;
   coord_type trace_minor_lo;
   delta_type trace_minor_delta;
   coord_type trace_major_pos;
   bit        trace_x_major;
   bit        trace_active;
   page_type  trace_page;
   color_type trace_color;

   int error_count    = 0;
   int starts_sent    = 0;
   int nexts_sent     = 0;
   int pixels_seen    = 0;
   int cycle_count    = 0;
   int countable      = 0;
   bit sender_idles   = 1'b1;

   function automatic void trace_pixel(input line_cmd_type cmd, output bit emits,
                                       output pixel_type px);
      int x0, y0, x1, y1, dx, dy, a0, a1, b0, b1, tmp, offset, span, minor;
      bit is_last;
      emits = 1'b0;
      is_last = 1'b0;
      px = '0;
      if (cmd.operation == OP_START) begin
         x0 = cmd.x_start;
         y0 = cmd.y_start;
         x1 = cmd.x_end;
         y1 = cmd.y_end;
         dx = (x1 >= x0) ? x1 - x0 : x0 - x1;
         dy = (y1 >= y0) ? y1 - y0 : y0 - y1;
         trace_page = cmd.page_base;
         trace_color = cmd.pen_color;
         trace_x_major = (dx >= dy);
         if (trace_x_major) begin
            a0 = x0; a1 = x1; b0 = y0; b1 = y1;
         end else begin
            a0 = y0; a1 = y1; b0 = x0; b1 = x1;
         end
         if (a1 < a0) begin
            tmp = a0; a0 = a1; a1 = tmp;
            tmp = b0; b0 = b1; b1 = tmp;
         end
         trace_major_lo = coord_type'(a0);
         trace_major_hi = coord_type'(a1);
         trace_minor_lo = coord_type'(b0);
         trace_minor_delta = delta_type'(b1 - b0);
         trace_major_pos = coord_type'(a0);
         is_last = (a0 == a1);
         trace_active = !is_last;
         emits = 1'b1;
      end else if (trace_active) begin
         trace_major_pos = trace_major_pos + 1'b1;
         is_last = (trace_major_pos >= trace_major_hi);
         if (is_last) trace_active = 1'b0;
         emits = 1'b1;
      end
      if (emits) begin
         offset = int'(trace_major_pos) - int'(trace_major_lo);
         span = int'(trace_major_hi) - int'(trace_major_lo);
         minor = int'(trace_minor_lo);
         if (offset != 0 && span != 0) minor = minor + (offset * int'(trace_minor_delta)) / span;
         px.x = trace_x_major ? trace_major_pos : coord_type'(minor);
         px.y = trace_x_major ? coord_type'(minor) : trace_major_pos;
         px.page = trace_page;
         px.color = trace_color;
         px.last = is_last;
      end
   endfunction

   task automatic queue_cmd(input logic op, input int xs, input int ys, input int xe,
                            input int ye, input int page, input int color);
      line_cmd_type cmd;
      cmd.operation = op;
      cmd.x_start = coord_type'(xs);
      cmd.y_start = coord_type'(ys);
      cmd.x_end = coord_type'(xe);
      cmd.y_end = coord_type'(ye);
      cmd.page_base = page_type'(page);
      cmd.pen_color = color_type'(color);
      cmd.gap = sender_idles ? 4'($urandom_range(0, 13)) : 4'd0;
      cmds_pending.push_back(cmd);
   endtask

   function automatic int clamp_coord(input int v);
      if (v < 0) return 0;
      if (v > COORD_MAX) return COORD_MAX;
      return v;
   endfunction

   task automatic queue_next();
      queue_cmd(OP_NEXT, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                $urandom_range(0, 65535), $urandom_range(0, 255));
   endtask

   // a start followed by a walk of next requests, mostly to the end of the line
   task automatic queue_line(input int max_delta);
      int x0, y0, x1, y1, ox, oy, span, walk, pick;
      x0 = $urandom_range(0, COORD_MAX);
      y0 = $urandom_range(0, COORD_MAX);
      if (max_delta >= COORD_MAX) begin
         x1 = $urandom_range(0, COORD_MAX);
         y1 = $urandom_range(0, COORD_MAX);
      end else begin
         ox = $urandom_range(0, 2 * max_delta);
         oy = $urandom_range(0, 2 * max_delta);
         x1 = clamp_coord(x0 + ox - max_delta);
         y1 = clamp_coord(y0 + oy - max_delta);
      end
      ox = (x1 >= x0) ? x1 - x0 : x0 - x1;
      oy = (y1 >= y0) ? y1 - y0 : y0 - y1;
      span = (ox >= oy) ? ox : oy;
      pick = $urandom_range(0, 99);
      if (max_delta >= COORD_MAX) walk = $urandom_range(0, 20);
      else if (pick < 70) walk = span;
      else if (pick < 85) walk = $urandom_range(0, span);
      else walk = span + $urandom_range(1, 3);
      queue_cmd(OP_START, x0, y0, x1, y1, $urandom_range(0, 65535), $urandom_range(0, 255));
      countable += 1 + walk;
      repeat (walk) queue_next();
   endtask

   // request driver
   line_cmd_type drv_cmd;
   logic [3:0]   drv_wait;
   bit           drv_emits;
   pixel_type    drv_pixel;

   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         drv_wait = '0;
         trace_major_lo = '0;
         trace_major_hi = '0;
         trace_minor_lo = '0;
         trace_minor_delta = '0;
         trace_major_pos = '0;
         trace_x_major = 1'b1;
         trace_active = 1'b0;
         trace_page = '0;
         trace_color = '0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            trace_pixel(drv_cmd, drv_emits, drv_pixel);
            if (drv_emits) pixels_due.push_back(drv_pixel);
            if (drv_cmd.operation == OP_START) starts_sent++;
            else nexts_sent++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (drv_wait != 0) begin
               drv_wait = drv_wait - 1'b1;
               req_chan.valid <= 1'b0;
            end else if (cmds_pending.size() != 0) begin
               drv_cmd = cmds_pending.pop_front();
               drv_wait = drv_cmd.gap;
               req_chan.valid <= 1'b1;
               req_chan.operation <= drv_cmd.operation;
               req_chan.x_start <= drv_cmd.x_start;
               req_chan.y_start <= drv_cmd.y_start;
               req_chan.x_end <= drv_cmd.x_end;
               req_chan.y_end <= drv_cmd.y_end;
               req_chan.page_base <= drv_cmd.page_base;
               req_chan.pen_color <= drv_cmd.pen_color;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // pixel monitor
   int        mon_stall;
   int        mon_hold;
   pixel_type mon_due;

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         mon_stall = 0;
         mon_hold = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            pixels_seen++;
            if (pixels_due.size() == 0) begin
               $error("pixel with no expectation: x %0d y %0d", rsp_chan.pixel_x,
                      rsp_chan.pixel_y);
               error_count++;
            end else begin
               mon_due = pixels_due.pop_front();
               if (rsp_chan.pixel_x !== mon_due.x) begin
                  $error("pixel_x mismatch: expected %0d, actual %0d", mon_due.x,
                         rsp_chan.pixel_x);
                  error_count++;
               end
               if (rsp_chan.pixel_y !== mon_due.y) begin
                  $error("pixel_y mismatch: expected %0d, actual %0d", mon_due.y,
                         rsp_chan.pixel_y);
                  error_count++;
               end
               if (rsp_chan.pixel_page !== mon_due.page) begin
                  $error("pixel_page mismatch: expected %0h, actual %0h", mon_due.page,
                         rsp_chan.pixel_page);
                  error_count++;
               end
               if (rsp_chan.pixel_color !== mon_due.color) begin
                  $error("pixel_color mismatch: expected %0h, actual %0h", mon_due.color,
                         rsp_chan.pixel_color);
                  error_count++;
               end
               if (rsp_chan.last_pixel !== mon_due.last) begin
                  $error("last_pixel mismatch: expected %0b, actual %0b", mon_due.last,
                         rsp_chan.last_pixel);
                  error_count++;
               end
            end
            mon_stall = (((pixels_seen / 150) % 3) == 1) ? 0 : $urandom_range(0, 13);
            if (pixels_seen == HOLD_AT) mon_hold = HOLD_CYCLES;
         end
         if (mon_hold > 0) begin
            mon_hold--;
            rsp_chan.ready <= 1'b0;
         end else if (mon_stall > 0) begin
            mon_stall--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d pixels outstanding", cycle_count,
                  pixels_due.size());
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      int pick;
      req_chan.valid = 1'b0;
      req_chan.operation = OP_START;
      req_chan.x_start = '0;
      req_chan.y_start = '0;
      req_chan.x_end = '0;
      req_chan.y_end = '0;
      req_chan.page_base = '0;
      req_chan.pen_color = '0;
      rsp_chan.ready = 1'b0;

      // next with no line, zero length line, tie diagonals, steep lines, short line
      queue_next();
      queue_cmd(OP_START, 0, 0, 0, 0, 0, 0);
      queue_next();
      queue_cmd(OP_START, COORD_MAX, COORD_MAX, 0, 0, 16'hffff, 8'hff);
      repeat (3) queue_next();
      queue_cmd(OP_START, 0, COORD_MAX, COORD_MAX, 0, 16'h5a5a, 8'ha5);
      repeat (2) queue_next();
      queue_cmd(OP_START, 3, 0, 0, 7, 16'h0001, 8'h80);
      repeat (8) queue_next();
      queue_cmd(OP_START, COORD_MAX, 0, COORD_MAX - 1, 0, 16'h8000, 8'h01);
      queue_next();
      queue_cmd(OP_START, 512, 100, 512, COORD_MAX, 16'h1234, 8'h7e);
      queue_next();

      while (countable < LINE_ITEMS) begin
         sender_idles = ((countable / 120) % 4) != 3;
         pick = $urandom_range(0, 99);
         if (pick < 80) queue_line(15);
         else if (pick < 88) queue_line(COORD_MAX);
         else if (pick < 94) begin
            queue_cmd(OP_START, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                      $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                      $urandom_range(0, 65535), $urandom_range(0, 255));
            countable++;
         end else begin
            queue_next();
            countable++;
         end
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (cmds_pending.size() != 0 || req_chan.valid || pixels_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (pixels_due.size() != 0) begin
         $error("%0d expected pixels never arrived", pixels_due.size());
         error_count++;
      end
      $display("drew %0d lines with %0d next requests, %0d pixels compared in %0d cycles",
               starts_sent, nexts_sent, pixels_seen, cycle_count);
      $display("receiver held off %0d cycles once, %0d mismatches", HOLD_CYCLES, error_count);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
